// File: rtl/core/gda_pkg.sv
// Package for the Gregorian date adder: field widths, calendar constants,
// the month-length table and the command and status structs.
// No dependencies.
package gda_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 17;
    localparam int CENT_W   = 7;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
    localparam logic [DAY_W-1:0]   FEB_LEAP  = 5'd29;

    localparam logic [CENT_W-1:0]  CENT_LAST = 7'd99;
    localparam logic [YEAR_W-1:0]  CENTURY   = 14'd100;

    // Division of a year below 10000 by 100 as (year * 5243) >> 19.
    localparam int PROD_W      = 27;
    localparam int RECIP_SHIFT = 19;
    localparam logic [PROD_W-1:0] RECIP_100 = 27'd5243;

    localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic load;
        logic div;
        logic rem;
        logic fix;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
    } status_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == MONTH_FEB && leap) begin
            len = FEB_LEAP;
        end
        else if (m == 4'd0 || m > MONTH_DEC) begin
            len = DAY_LAST;
        end
        else begin
            len = MONTH_LEN[m];
        end
        return len;
    endfunction

endpackage

// File: rtl/core/gda_in_if.sv
// Request channel of the Gregorian date adder: valid, ready and the start date.
// Depends on gda_pkg for the field widths.
interface gda_in_if;
    logic                          valid;
    logic                          ready;
    logic [gda_pkg::YEAR_W-1:0]    start_year;
    logic [gda_pkg::MONTH_W-1:0]   start_month;
    logic [gda_pkg::DAY_W-1:0]     start_day;
    logic signed [gda_pkg::OFFSET_W-1:0] day_offset;

    modport source (output valid, output start_year, output start_month,
                    output start_day, output day_offset, input ready);
    modport sink (input valid, input start_year, input start_month,
                  input start_day, input day_offset, output ready);
endinterface

// File: rtl/core/gda_out_if.sv
// Result channel of the Gregorian date adder: valid, ready and the result date.
// Depends on gda_pkg for the field widths.
interface gda_out_if;
    logic                        valid;
    logic                        ready;
    logic [gda_pkg::YEAR_W-1:0]  result_year;
    logic [gda_pkg::MONTH_W-1:0] result_month;
    logic [gda_pkg::DAY_W-1:0]   result_day;
    logic                        out_of_range;

    modport source (output valid, output result_year, output result_month,
                    output result_day, output out_of_range, input ready);
    modport sink (input valid, input result_year, input result_month,
                  input result_day, input out_of_range, output ready);
endinterface

// File: rtl/core/gda_controller.sv
// Sequencer of the Gregorian date adder: steps one request through load,
// year split, day fix and the month walk, and owns the result valid flag.
// Depends on gda_pkg.
module gda_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gda_pkg::cmd_t     cmd,
    input  gda_pkg::status_t  status
);
    import gda_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_FIX,
        S_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!status.walk_done)
                begin
                    cmd.step = 1'b1;
                end
                else if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/gda_datapath.sv
// Datapath of the Gregorian date adder: input clamping, year split into
// century and year-of-century, the one-month-per-cycle walk and the result register.
// Depends on gda_pkg.
module gda_datapath #(
    parameter int MAX_OFFSET = 65535
) (
    input  logic                              clk,
    input  gda_pkg::cmd_t                     cmd,
    output gda_pkg::status_t                  status,
    input  logic [gda_pkg::YEAR_W-1:0]        start_year,
    input  logic [gda_pkg::MONTH_W-1:0]       start_month,
    input  logic [gda_pkg::DAY_W-1:0]         start_day,
    input  logic signed [gda_pkg::OFFSET_W-1:0] day_offset,
    output logic [gda_pkg::YEAR_W-1:0]        result_year,
    output logic [gda_pkg::MONTH_W-1:0]       result_month,
    output logic [gda_pkg::DAY_W-1:0]         result_day,
    output logic                              out_of_range
);
    import gda_pkg::*;

    localparam int SPAN_W = $clog2(MAX_OFFSET + 32) + 1;
    localparam int D_W    = (SPAN_W > OFFSET_W + 1) ? SPAN_W : OFFSET_W + 1;
    localparam logic signed [D_W-1:0] MAX_POS = D_W'(MAX_OFFSET);
    localparam logic signed [D_W-1:0] MAX_NEG = -D_W'(MAX_OFFSET);

    logic [YEAR_W-1:0]        year_reg;
    logic [MONTH_W-1:0]       month_reg;
    logic [DAY_W-1:0]         day_in_reg;
    logic signed [D_W-1:0]    off_reg;
    logic signed [D_W-1:0]    d_reg;
    logic                     back_reg;
    logic                     flag_reg;
    logic [CENT_W-1:0]        quot_reg;
    logic [CENT_W-1:0]        rem_reg;
    logic [1:0]               cen_reg;

    logic [YEAR_W-1:0]        year_res_reg;
    logic [MONTH_W-1:0]       month_res_reg;
    logic [DAY_W-1:0]         day_res_reg;
    logic                     flag_res_reg;

    logic                     leap;
    logic [DAY_W-1:0]         ml_cur;
    logic [DAY_W-1:0]         ml_prev;
    logic [MONTH_W-1:0]       month_prev;
    logic signed [D_W-1:0]    ml_cur_s;
    logic signed [D_W-1:0]    ml_prev_s;
    logic signed [D_W-1:0]    off_ext;
    logic [PROD_W-1:0]        prod;
    logic [YEAR_W-1:0]        rem_full;
    logic [DAY_W-1:0]         day_fixed;
    logic                     fwd_more;
    logic                     back_more;

    assign leap       = (rem_reg == '0) ? (cen_reg == 2'd0) : (year_reg[1:0] == 2'd0);
    assign ml_cur     = month_len(month_reg, leap);
    assign month_prev = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - MONTH_JAN;
    assign ml_prev    = month_len(month_prev, leap);
    assign ml_cur_s   = $signed({{(D_W-DAY_W){1'b0}}, ml_cur});
    assign ml_prev_s  = $signed({{(D_W-DAY_W){1'b0}}, ml_prev});
    assign off_ext    = $signed({{(D_W-OFFSET_W){day_offset[OFFSET_W-1]}}, day_offset});
    assign prod       = PROD_W'(year_reg) * RECIP_100;
    assign rem_full   = year_reg - YEAR_W'(quot_reg) * CENTURY;
    assign fwd_more   = (d_reg > ml_cur_s);
    assign back_more  = (d_reg <= $signed(D_W'(0)));

    always_comb
    begin
        if (day_in_reg == '0)
        begin
            day_fixed = DAY_FIRST;
        end
        else if (day_in_reg > ml_cur)
        begin
            day_fixed = ml_cur;
        end
        else
        begin
            day_fixed = day_in_reg;
        end
    end

    assign status.walk_done = back_reg ? !back_more : !fwd_more;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (start_year < YEAR_MIN)
            begin
                year_reg <= YEAR_MIN;
            end
            else if (start_year > YEAR_MAX)
            begin
                year_reg <= YEAR_MAX;
            end
            else
            begin
                year_reg <= start_year;
            end
            if (start_month < MONTH_JAN)
            begin
                month_reg <= MONTH_JAN;
            end
            else if (start_month > MONTH_DEC)
            begin
                month_reg <= MONTH_DEC;
            end
            else
            begin
                month_reg <= start_month;
            end
            if (off_ext > MAX_POS)
            begin
                off_reg <= MAX_POS;
            end
            else if (off_ext < MAX_NEG)
            begin
                off_reg <= MAX_NEG;
            end
            else
            begin
                off_reg <= off_ext;
            end
            day_in_reg <= start_day;
            back_reg   <= day_offset[OFFSET_W-1];
            flag_reg   <= 1'b0;
        end

        if (cmd.div)
        begin
            quot_reg <= prod[RECIP_SHIFT +: CENT_W];
        end

        if (cmd.rem)
        begin
            rem_reg <= rem_full[CENT_W-1:0];
            cen_reg <= quot_reg[1:0];
        end

        if (cmd.fix)
        begin
            d_reg <= $signed({{(D_W-DAY_W){1'b0}}, day_fixed}) + off_reg;
        end

        if (cmd.step)
        begin
            if (!back_reg)
            begin
                if (month_reg == MONTH_DEC)
                begin
                    if (year_reg == YEAR_MAX)
                    begin
                        d_reg    <= $signed({{(D_W-DAY_W){1'b0}}, DAY_LAST});
                        flag_reg <= 1'b1;
                    end
                    else
                    begin
                        d_reg     <= d_reg - ml_cur_s;
                        month_reg <= MONTH_JAN;
                        year_reg  <= year_reg + YEAR_MIN;
                        if (rem_reg == CENT_LAST)
                        begin
                            rem_reg <= '0;
                            cen_reg <= cen_reg + 2'd1;
                        end
                        else
                        begin
                            rem_reg <= rem_reg + CENT_W'(1);
                        end
                    end
                end
                else
                begin
                    d_reg     <= d_reg - ml_cur_s;
                    month_reg <= month_reg + MONTH_JAN;
                end
            end
            else
            begin
                if (month_reg == MONTH_JAN)
                begin
                    if (year_reg == YEAR_MIN)
                    begin
                        d_reg    <= $signed({{(D_W-DAY_W){1'b0}}, DAY_FIRST});
                        flag_reg <= 1'b1;
                    end
                    else
                    begin
                        d_reg     <= d_reg + ml_prev_s;
                        month_reg <= MONTH_DEC;
                        year_reg  <= year_reg - YEAR_MIN;
                        if (rem_reg == '0)
                        begin
                            rem_reg <= CENT_LAST;
                            cen_reg <= cen_reg - 2'd1;
                        end
                        else
                        begin
                            rem_reg <= rem_reg - CENT_W'(1);
                        end
                    end
                end
                else
                begin
                    d_reg     <= d_reg + ml_prev_s;
                    month_reg <= month_prev;
                end
            end
        end

        if (cmd.emit)
        begin
            year_res_reg  <= year_reg;
            month_res_reg <= month_reg;
            day_res_reg   <= d_reg[DAY_W-1:0];
            flag_res_reg  <= flag_reg;
        end
    end

    assign result_year  = year_res_reg;
    assign result_month = month_res_reg;
    assign result_day   = day_res_reg;
    assign out_of_range = flag_res_reg;

endmodule

// File: rtl/core/gregorian_date_add_days.sv
// Gregorian date adder: adds a signed day offset to a year-month-day date,
// walking one calendar month per clock with the 400/100/4 leap-year rule.
// Depends on gda_pkg, gda_in_if, gda_out_if, gda_controller and gda_datapath.
//
// One request at a time is in work; it steps through load, year split, day fix
// and the month walk. A finished result waits in an output register, so the
// next request is taken while it is pending. Out-of-range inputs are clamped,
// and a result that leaves years 1 to 9999 saturates to the nearest bound date
// with out_of_range set.
module gregorian_date_add_days #(
    parameter int MAX_OFFSET = 65535
) (
    input  logic      clk,
    input  logic      rst_n,
    gda_in_if.sink    request,
    gda_out_if.source result
);
    import gda_pkg::*;

    cmd_t    cmd;
    status_t status;

    gda_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .status    (status)
    );

    gda_datapath #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .start_year   (request.start_year),
        .start_month  (request.start_month),
        .start_day    (request.start_day),
        .day_offset   (request.day_offset),
        .result_year  (result.result_year),
        .result_month (result.result_month),
        .result_day   (result.result_day),
        .out_of_range (result.out_of_range)
    );

`ifndef SYNTHESIS
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("request accepted while another is in work");

    a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.out_of_range |->
            (result.result_year == YEAR_MAX && result.result_month == MONTH_DEC &&
             result.result_day == DAY_LAST) ||
            (result.result_year == YEAR_MIN && result.result_month == MONTH_JAN &&
             result.result_day == DAY_FIRST))
        else $error("out_of_range result is not a bound date");

    a_result_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.result_month >= MONTH_JAN &&
            result.result_month <= MONTH_DEC && result.result_day >= DAY_FIRST &&
            result.result_year >= YEAR_MIN && result.result_year <= YEAR_MAX)
        else $error("result date fields out of range");

    a_emit_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.walk_done && !cmd.step)
        else $error("result stored before the month walk finished");
`endif

endmodule
